// File: rtl/core/i2cm_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
// Depends on nothing; imported by i2cm_seq_core and the top level.
`default_nettype none

package i2cm_pkg;

	localparam int unsigned DelayWidth = 18;
	localparam int unsigned TicksWidth = 16;
	localparam int unsigned LimitWidth = 8;
	localparam int unsigned CfgIdxWidth = 2;

	// Configuration register indexes
	localparam logic [CfgIdxWidth-1:0] CFG_TICKS_PER_UNIT = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_ACK_TIMEOUT = 2'd1;

	localparam logic [TicksWidth-1:0] TICKS_RESET = 16'd8;
	localparam logic [LimitWidth-1:0] LIMIT_RESET = 8'd250;

	// Command codes
	typedef enum logic [2:0] {
		REQ_START    = 3'd0,
		REQ_STOP     = 3'd1,
		REQ_WRITE    = 3'd2,
		REQ_WAIT_ACK = 3'd3,
		REQ_READ     = 3'd4
	} req_t;

	// Bus phases
	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_ST_A    = 4'd1,
		PH_ST_B    = 4'd2,
		PH_SP_A    = 4'd3,
		PH_SP_B    = 4'd4,
		PH_W_SET   = 4'd5,
		PH_W_HI    = 4'd6,
		PH_W_LO    = 4'd7,
		PH_WA_REL  = 4'd8,
		PH_WA_HI   = 4'd9,
		PH_WA_POLL = 4'd10,
		PH_R_LO    = 4'd11,
		PH_R_HI    = 4'd12,
		PH_A_SET   = 4'd13,
		PH_A_HI    = 4'd14
	} phase_t;

	// One tick's word
	typedef struct packed {
		logic       sda_sample;
		logic       cmd_valid;
		logic [2:0] req_type;
		logic [7:0] tx_byte;
		logic       send_ack;
	} item_t;

	// Line and status view after a tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} status_t;

endpackage : i2cm_pkg

`default_nettype wire

// File: rtl/core/i2cm_seq_core.sv
// Bit-level sequencer state machine of the I2C master: one tick per step.
// Depends on i2cm_pkg for the phase, command, item and status types.
`default_nettype none

module i2cm_seq_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                step,
	input  wire i2cm_pkg::item_t                     item,
	input  wire logic [i2cm_pkg::TicksWidth-1:0]     ticks_per_unit,
	input  wire logic [i2cm_pkg::LimitWidth-1:0]     ack_timeout_limit,
	output i2cm_pkg::status_t                        status_nxt
);
	import i2cm_pkg::*;

	phase_t                phase_q, phase_d;
	logic [3:0]            bit_count_q, bit_count_d;
	logic [7:0]            shift_q, shift_d;
	logic [DelayWidth-1:0] delay_q, delay_d;
	logic [7:0]            timeout_q, timeout_d;
	logic                  scl_q, scl_d;
	logic                  sda_q, sda_d;
	logic                  dir_q, dir_d;
	logic                  fail_q, fail_d;
	logic                  ack_choice_q, ack_choice_d;
	logic [7:0]            rx_q, rx_d;
	logic                  done_d;

	logic [DelayWidth-1:0] unit1, unit2, unit4, delay_dec;
	logic [3:0]            bit_inc;

	// Phase lengths: a zero unit counts as one tick
	always_comb begin
		unit1 = (ticks_per_unit == '0) ? DelayWidth'(1)
			: DelayWidth'(ticks_per_unit);
		unit2 = unit1 << 1;
		unit4 = unit1 << 2;
		delay_dec = (delay_q != '0) ? delay_q - DelayWidth'(1) : delay_q;
		bit_inc = bit_count_q + 4'd1;
	end

	// Next state for one tick
	always_comb begin
		phase_d = phase_q;
		bit_count_d = bit_count_q;
		shift_d = shift_q;
		delay_d = delay_q;
		timeout_d = timeout_q;
		scl_d = scl_q;
		sda_d = sda_q;
		dir_d = dir_q;
		fail_d = fail_q;
		ack_choice_d = ack_choice_q;
		rx_d = rx_q;
		done_d = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.cmd_valid) begin
				unique case (item.req_type)
					REQ_START: begin
						dir_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
						phase_d = PH_ST_A; delay_d = unit4;
					end
					REQ_STOP: begin
						dir_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
						phase_d = PH_SP_A; delay_d = unit4;
					end
					REQ_WRITE: begin
						dir_d = 1'b1; scl_d = 1'b0; bit_count_d = '0;
						sda_d = item.tx_byte[7];
						shift_d = {item.tx_byte[6:0], 1'b0};
						phase_d = PH_W_SET; delay_d = unit2;
					end
					REQ_WAIT_ACK: begin
						timeout_d = '0; fail_d = 1'b0;
						dir_d = 1'b0; sda_d = 1'b1;
						phase_d = PH_WA_REL; delay_d = unit1;
					end
					REQ_READ: begin
						ack_choice_d = item.send_ack; dir_d = 1'b0;
						shift_d = '0; bit_count_d = '0; scl_d = 1'b0;
						phase_d = PH_R_LO; delay_d = unit2;
					end
					default: begin
					end
				endcase
			end
		end else if (phase_q == PH_WA_POLL) begin
			// Poll the slave's acknowledge once per tick
			priority if (!item.sda_sample) begin
				scl_d = 1'b0; done_d = 1'b1; phase_d = PH_IDLE;
			end else if (timeout_q >= ack_timeout_limit) begin
				fail_d = 1'b1;
				dir_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
				phase_d = PH_SP_A; delay_d = unit4;
			end else begin
				timeout_d = timeout_q + 8'd1;
			end
		end else begin
			delay_d = delay_dec;
			if (delay_dec == '0) begin
				unique case (phase_q)
					PH_ST_A: begin
						sda_d = 1'b0; phase_d = PH_ST_B; delay_d = unit4;
					end
					PH_ST_B: begin
						scl_d = 1'b0; done_d = 1'b1; phase_d = PH_IDLE;
					end
					PH_SP_A: begin
						scl_d = 1'b1; sda_d = 1'b1;
						phase_d = PH_SP_B; delay_d = unit4;
					end
					PH_SP_B: begin
						done_d = 1'b1; phase_d = PH_IDLE;
					end
					PH_W_SET: begin
						scl_d = 1'b1; phase_d = PH_W_HI; delay_d = unit2;
					end
					PH_W_HI: begin
						scl_d = 1'b0; phase_d = PH_W_LO; delay_d = unit2;
					end
					PH_W_LO: begin
						bit_count_d = bit_inc;
						if (bit_inc >= 4'd8) begin
							done_d = 1'b1; phase_d = PH_IDLE;
						end else begin
							sda_d = shift_q[7];
							shift_d = {shift_q[6:0], 1'b0};
							phase_d = PH_W_SET; delay_d = unit2;
						end
					end
					PH_WA_REL: begin
						scl_d = 1'b1; phase_d = PH_WA_HI; delay_d = unit1;
					end
					PH_WA_HI: begin
						phase_d = PH_WA_POLL;
					end
					PH_R_LO: begin
						scl_d = 1'b1;
						shift_d = {shift_q[6:0], item.sda_sample};
						phase_d = PH_R_HI; delay_d = unit1;
					end
					PH_R_HI: begin
						bit_count_d = bit_inc;
						scl_d = 1'b0;
						if (bit_inc >= 4'd8) begin
							rx_d = shift_q;
							dir_d = 1'b1;
							sda_d = !ack_choice_q;
							phase_d = PH_A_SET; delay_d = unit2;
						end else begin
							phase_d = PH_R_LO; delay_d = unit2;
						end
					end
					PH_A_SET: begin
						scl_d = 1'b1; phase_d = PH_A_HI; delay_d = unit2;
					end
					PH_A_HI: begin
						scl_d = 1'b0; done_d = 1'b1; phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// Status after this tick
	always_comb begin
		status_nxt.scl_level = scl_d;
		status_nxt.sda_level = sda_d;
		status_nxt.sda_drive = dir_d;
		status_nxt.busy_res = (phase_d != PH_IDLE);
		status_nxt.done_res = done_d;
		status_nxt.rx_byte = rx_d;
		status_nxt.ack_failed = fail_d;
	end

	// Advance state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_count_q <= '0;
			shift_q <= '0;
			delay_q <= '0;
			timeout_q <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			dir_q <= 1'b1;
			fail_q <= 1'b0;
			ack_choice_q <= 1'b0;
			rx_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_count_q <= bit_count_d;
			shift_q <= shift_d;
			delay_q <= delay_d;
			timeout_q <= timeout_d;
			scl_q <= scl_d;
			sda_q <= sda_d;
			dir_q <= dir_d;
			fail_q <= fail_d;
			ack_choice_q <= ack_choice_d;
			rx_q <= rx_d;
		end
	end

endmodule : i2cm_seq_core

`default_nettype wire

// File: rtl/core/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master bit sequencer: stream ports, configuration
// registers and result register. Depends on i2cm_pkg and i2cm_seq_core.
//
// Each input word is one bus tick; the block takes one word per clock cycle
// unless the result is stalled, and answers every word with exactly one result
// word in the cycle after it is taken. The sequencer state advances in the same
// cycle the word is taken. The result register holds one word: a new tick is
// taken whenever that register is empty or its word is taken in the same cycle,
// so throughput is one word per cycle while the consumer keeps tready high, and
// a stalled result stalls the input. Phase lengths are counted in accepted
// ticks, not clock cycles. Write configuration only while the sequencer is idle.
`default_nettype none

module i2c_master_bit_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Tick stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // sda_sample, tx_byte[8:1], send_ack[9]
	input  wire logic [3:0]  s_axis_tuser,  // cmd_valid, req_type[3:1]
	// Result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // scl_level, sda_level, sda_drive,
	                                        // busy_res, done_res, rx_byte[12:5],
	                                        // ack_failed[13]
	// Configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [i2cm_pkg::CfgIdxWidth-1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);
	import i2cm_pkg::*;

	logic [TicksWidth-1:0] ticks_q;
	logic [LimitWidth-1:0] limit_q;
	item_t                 item;
	status_t               status_nxt;
	status_t               res_q;
	logic                  m_valid_q;
	logic                  s_fire;

	// Unpack the tick word
	always_comb begin
		item.sda_sample = s_axis_tdata[0];
		item.tx_byte = s_axis_tdata[8:1];
		item.send_ack = s_axis_tdata[9];
		item.cmd_valid = s_axis_tuser[0];
		item.req_type = s_axis_tuser[3:1];
	end

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_TICKS_PER_UNIT)
				ticks_q <= cfg_data;
			else if (cfg_index == CFG_ACK_TIMEOUT)
				limit_q <= cfg_data[LimitWidth-1:0];
		end
	end

	i2cm_seq_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (s_fire),
		.item             (item),
		.ticks_per_unit   (ticks_q),
		.ack_timeout_limit(limit_q),
		.status_nxt       (status_nxt)
	);

	// Result register: fill on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire)
			res_q <= status_nxt;
	end

	// Pack the result word
	always_comb begin
		m_axis_tvalid = m_valid_q;
		m_axis_tdata = {2'b00, res_q.ack_failed, res_q.rx_byte, res_q.done_res,
			res_q.busy_res, res_q.sda_drive, res_q.sda_level, res_q.scl_level};
	end

	// An accepted tick always leaves a result waiting
	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> m_valid_q)
		else $error("accepted tick left no result");

	// A completion always lands the sequencer back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done reported while still busy");

	// A stalled result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |=> $stable(res_q))
		else $error("result changed under stall");

endmodule : i2c_master_bit_sequencer_unit

`default_nettype wire
